>>> src/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window mean core.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int LEN_BITS = 9;
   localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

endpackage

>>> src/swm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_div
// Radix-2 restoring divider: signed numerator over an unsigned nonzero
// denominator, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module swm_div #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic        [DEN_BITS-1:0] den,
   output logic                       done,
   output logic signed [NUM_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[NUM_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[NUM_BITS-1];
         den_in  = den;
         rem_in  = '0;
         quo_in  = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
      end else if (busy_ff) begin
         if (!diff[DEN_BITS]) begin
            rem_in = diff[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> src/sliding_window_mean_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_core
// Moving average over the most recent window_len samples, kept in a ring
// memory with a running sum and fill count.
// ----------------------------------------------------------------------------
// sequence: IDLE takes the request, SUM updates the running sum, START launches
//   the one-bit-per-cycle divider, WAIT holds for its quotient and DONE registers the
//   response once the output slot is free; a zero window length goes from IDLE
//   to DONE with a zero mean; a new request waits until the core is back in IDLE
// reset: synchronous, clears pointer, count, sum and handshakes; window_len
//   returns to 16, sample memory content is left as is
// ----------------------------------------------------------------------------
module sliding_window_mean_core #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_mean,
   input  logic                          csr_wr_en,
   input  logic [swm_pkg::LEN_BITS-1:0]  csr_wr_data
);

   localparam int ADDR_BITS = $clog2(MAX_WINDOW);
   localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + ADDR_BITS;
   localparam int EXT_BITS  = SUM_BITS - SAMPLE_BITS;

   swm_pkg::state_type state_ff, state_in;

   logic [swm_pkg::LEN_BITS-1:0] window_len_ff;
   logic [ADDR_BITS-1:0]         wp_ff, wp_in;
   logic [CNT_BITS-1:0]          fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                         full_ff, full_in;
   logic [SAMPLE_BITS-1:0]       sample_ff;
   logic [SAMPLE_BITS-1:0]       mean_ff, mean_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]       rsp_mean_ff, rsp_mean_in;

   logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   mem_en;

   logic [CNT_BITS-1:0]  eff_len;
   logic [ADDR_BITS-1:0] back;
   logic [ADDR_BITS:0]   diff;
   logic                 req_xfer;
   logic                 div_start;
   logic                 div_done;
   logic signed [SUM_BITS-1:0] div_quot;
   logic signed [SUM_BITS-1:0] new_ext;
   logic signed [SUM_BITS-1:0] old_ext;

   assign eff_len = (32'(window_len_ff) > 32'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW)
                                                           : CNT_BITS'(window_len_ff);

   // oldest sample sits fill slots behind the write pointer
   assign back = (fill_ff == CNT_BITS'(MAX_WINDOW)) ? '0 : fill_ff[ADDR_BITS-1:0];
   assign diff = {1'b0, wp_ff} - {1'b0, back};
   assign rd_addr = diff[ADDR_BITS] ? ADDR_BITS'(diff + (ADDR_BITS + 1)'(MAX_WINDOW))
                                    : diff[ADDR_BITS-1:0];

   assign req_ready = (state_ff == swm_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign mem_en    = req_xfer && (eff_len != '0);

   assign new_ext = $signed({{EXT_BITS{sample_ff[SAMPLE_BITS-1]}}, sample_ff});
   assign old_ext = $signed({{EXT_BITS{rd_data_ff[SAMPLE_BITS-1]}}, rd_data_ff});

   // read before write on the same slot returns the old sample
   always_ff @(posedge clock) begin
      if (mem_en) begin
         mem[wp_ff] <= req_sample;
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      full_in      = full_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      div_start    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (eff_len == '0) begin
                  mean_in  = '0;
                  state_in = swm_pkg::ST_DONE;
               end else begin
                  full_in  = (fill_ff >= eff_len);
                  state_in = swm_pkg::ST_SUM;
               end
            end
         end
         swm_pkg::ST_SUM: begin
            sum_in = full_ff ? sum_ff + new_ext - old_ext : sum_ff + new_ext;
            if (!full_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            wp_in    = (wp_ff == ADDR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
            state_in = swm_pkg::ST_START;
         end
         swm_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = swm_pkg::ST_WAIT;
         end
         swm_pkg::ST_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot[SAMPLE_BITS-1:0];
               state_in = swm_pkg::ST_DONE;
            end
         end
         swm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               state_in     = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
      // window length write clears the window
      if (csr_wr_en) begin
         wp_in   = '0;
         fill_in = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= swm_pkg::ST_IDLE;
         window_len_ff <= swm_pkg::LEN_RESET;
         wp_ff         <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      full_ff     <= full_in;
      mean_ff     <= mean_in;
      rsp_mean_ff <= rsp_mean_in;
      if (req_xfer) begin
         sample_ff <= req_sample;
      end
   end

   swm_div #(
      .NUM_BITS (SUM_BITS),
      .DEN_BITS (CNT_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_ff),
      .den   (fill_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean  = $signed(rsp_mean_ff);

endmodule

>>> verif/sliding_window_mean_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_core_tb
// Self-checking bench for the moving average core. A local window model
// (ring of samples, fill count, running sum) predicts the mean of every
// request transfer. The bench sweeps window lengths from zero past the
// memory depth, applies random idling on both channels and long response
// back-pressure, and compares every response with the predicted mean.
// ----------------------------------------------------------------------------
module sliding_window_mean_core_tb;

   localparam int MAX_WINDOW  = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_PRINTED = 50;
   localparam int EXP_DEPTH = 16;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_mean;
   logic                          csr_wr_en = 1'b0;
   logic [swm_pkg::LEN_BITS-1:0]  csr_wr_data = '0;

   // window model
   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [7:0]                    ring_ptr;
   logic [swm_pkg::LEN_BITS-1:0]  held_count;
   logic signed [23:0]            window_sum;
   logic [swm_pkg::LEN_BITS-1:0]  window_len_q;

   // expected means in transfer order
   logic signed [SAMPLE_BITS-1:0] expected_means [EXP_DEPTH];
   int exp_wr = 0;
   int exp_rd = 0;

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_request = 0;
   int stall_cycles = 0;

   sliding_window_mean_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_mean    (rsp_mean),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic void clear_window();
      ring_ptr = '0;
      held_count = '0;
      window_sum = '0;
   endfunction

   // returns the mean after taking in one sample
   function automatic logic signed [SAMPLE_BITS-1:0] advance_window(
      input logic signed [SAMPLE_BITS-1:0] s
   );
      int        len;
      int        quotient;
      logic [7:0] oldest_idx;
      len = (window_len_q > MAX_WINDOW) ? MAX_WINDOW : int'(window_len_q);
      if (len == 0) begin
         return '0;
      end
      if (held_count >= len) begin
         oldest_idx = ring_ptr - held_count[7:0];
         window_sum = window_sum - ring_mem[oldest_idx];
         while (held_count > len) begin
            held_count = held_count - 1'b1;
            oldest_idx = ring_ptr - held_count[7:0];
            window_sum = window_sum - ring_mem[oldest_idx];
         end
      end else begin
         held_count = held_count + 1'b1;
      end
      ring_mem[ring_ptr] = s;
      ring_ptr = ring_ptr + 1'b1;
      window_sum = window_sum + s;
      quotient = int'(window_sum) / int'(held_count);
      return quotient[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic [31:0] r;
      int          tmp;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: tmp = -32768;
         1: tmp = 32767;
         2: tmp = $urandom_range(0, 31) - 16;
         default: tmp = int'(r);
      endcase
      return tmp[SAMPLE_BITS-1:0];
   endfunction

   // response side: random ready, or a counted hold-off on request
   always @(posedge clock) begin
      static int hold_left = 0;
      if (rsp_hold_request > 0) begin
         hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_wr == exp_rd) begin
            report_mismatch($sformatf("response mean %0d with nothing pending", rsp_mean));
         end else begin
            want = expected_means[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_mean !== want) begin
               report_mismatch($sformatf("mean got %0d want %0d", rsp_mean, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("sliding_window_mean_core_tb: FAIL");
      $finish;
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      expected_means[exp_wr % EXP_DEPTH] = advance_window(s);
      exp_wr++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [swm_pkg::LEN_BITS-1:0] len);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_len_q = len;
      clear_window();
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // extremes, truncation toward zero, zero and oversized windows
   task automatic test_directed();
      send_sample(16'sh7fff);
      send_sample(-16'sd32768);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      write_window_len(9'd0);
      send_sample(16'sh7fff);
      send_sample(-16'sd32768);
      write_window_len(9'd1);
      send_sample(-16'sd32768);
      send_sample(16'sh7fff);
      send_sample(-16'sd5);
      write_window_len(9'd2);
      send_sample(-16'sd32768);
      send_sample(-16'sd32768);
      send_sample(16'sd7);
      send_sample(-16'sd8);
      write_window_len(9'd3);
      send_sample(-16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      write_window_len(9'd511);
      send_sample(16'sd100);
      send_sample(-16'sd200);
      send_sample(16'sd300);
   endtask

   // long response hold-off fills the core, then a full pause on requests
   task automatic test_backpressure();
      write_window_len(9'd4);
      rsp_hold_request = 400;
      repeat (16) send_sample(pick_sample());
      drain_results();
      repeat (6) send_sample(pick_sample());
   endtask

   task automatic test_random_windows();
      write_window_len(9'd0);
      repeat (15) send_sample(pick_sample());
      for (int seg = 0; seg < 3; seg++) begin
         write_window_len(swm_pkg::LEN_BITS'($urandom_range(1, 12)));
         repeat (50) send_sample(pick_sample());
      end
   endtask

   task automatic test_oversized_window();
      write_window_len(swm_pkg::LEN_BITS'($urandom_range(MAX_WINDOW + 1, 510)));
      repeat (270) send_sample(pick_sample());
   endtask

   // full depth at the negative extreme, then wrap with new content
   task automatic test_full_window();
      write_window_len(9'd256);
      repeat (MAX_WINDOW) send_sample(-16'sd32768);
      repeat (16) send_sample(16'sh7fff);
      repeat (16) send_sample(pick_sample());
   endtask

   initial begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
      window_len_q = swm_pkg::LEN_RESET;
      clear_window();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_idling(38, 69);
      test_directed();
      test_backpressure();
      test_random_windows();
      test_oversized_window();

      set_idling(69, 38);
      test_random_windows();

      set_idling(0, 0);
      test_full_window();
      test_random_windows();

      drain_results();
      if (exp_wr != exp_rd) begin
         report_mismatch($sformatf("%0d means never returned", exp_wr - exp_rd));
      end
      if (error_count == 0) begin
         $display("sliding_window_mean_core_tb: PASS");
      end else begin
         $display("sliding_window_mean_core_tb: FAIL");
      end
      $finish;
   end

endmodule
